>>> rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Used by tcw_ctrl, tcw_dpath and text_console_writer_unit; no dependencies.
`default_nettype none
package tcw_pkg;

	localparam int KIND_W  = 2;
	localparam int CODE_W  = 8;
	localparam int INDEX_W = 11;
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int BYTE_W  = 8;
	localparam int NIB_W   = 4;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_FG = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_BG = 1'd1;

	localparam logic [NIB_W-1:0] FG_RESET = 4'h7;
	localparam logic [NIB_W-1:0] BG_RESET = 4'h0;

	localparam logic [CODE_W-1:0] SPACE_CODE   = 8'h20;
	localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUT     = 2'd0,
		KIND_CLEAR   = 2'd1,
		KIND_REPAINT = 2'd2,
		KIND_READ    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SW_NONE   = 2'd0,
		SW_SCROLL = 2'd1,
		SW_CLEAR  = 2'd2,
		SW_PAINT  = 2'd3
	} sweep_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SCROLL = 7'b0000010,
		ST_PUT    = 7'b0000100,
		ST_CLEAR  = 7'b0001000,
		ST_PAINT  = 7'b0010000,
		ST_READ   = 7'b0100000,
		ST_FIN    = 7'b1000000
	} state_t;

	typedef struct packed {
		logic   load_in;
		sweep_t sweep;
		logic   put_go;
		logic   row_fix;
		logic   cursor_clear;
		logic   read_go;
		logic   out_load;
	} cmd_t;

	typedef struct packed {
		logic row_full;
		logic sweep_last;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

>>> rtl/tcw_ctrl.sv
// Sequencer for the text console writer: one-hot state machine that steps
// puts, scrolls, clears, repaints and reads. Depends on tcw_pkg.
`default_nettype none
module tcw_ctrl
	import tcw_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [KIND_W-1:0] in_kind,
	output logic                 in_ready,
	input  wire status_t         status,
	output cmd_t                 cmd
);

	state_t state_q;
	state_t state_d;
	kind_t  kind;

	assign kind     = kind_t'(in_kind);
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.sweep = SW_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					case (kind)
						KIND_PUT:     state_d = status.row_full ? ST_SCROLL : ST_PUT;
						KIND_CLEAR: begin
							cmd.cursor_clear = 1'b1;
							state_d = ST_CLEAR;
						end
						KIND_REPAINT: state_d = ST_PAINT;
						KIND_READ:    state_d = ST_READ;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCROLL: begin
				cmd.sweep = SW_SCROLL;
				if (status.sweep_last) begin
					cmd.row_fix = 1'b1;
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				if (status.out_free) begin
					cmd.put_go   = 1'b1;
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				cmd.sweep = SW_CLEAR;
				if (status.sweep_last) state_d = ST_FIN;
			end
			ST_PAINT: begin
				cmd.sweep = SW_PAINT;
				if (status.sweep_last) state_d = ST_FIN;
			end
			ST_READ: begin
				cmd.read_go = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

>>> rtl/tcw_dpath.sv
// Datapath for the text console writer: cell memories, cursor, sweep
// counter, write stage and result register. Depends on tcw_pkg.
`default_nettype none
module tcw_dpath
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output status_t                   status,
	input  wire logic [KIND_W-1:0]    in_kind,
	input  wire logic [CODE_W-1:0]    in_code,
	input  wire logic [INDEX_W-1:0]   in_index,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_wr_index,
	input  wire logic [NIB_W-1:0]     cfg_wr_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [COL_W-1:0]          out_col,
	output logic [ROW_W-1:0]          out_row,
	output logic [BYTE_W-1:0]         out_char,
	output logic [BYTE_W-1:0]         out_attr
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS + 1);
	localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_END   = AW'(CELLS - COLUMNS);
	localparam logic [AW:0]   COLS_WIDE  = (AW + 1)'(COLUMNS);
	localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
	localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] ROWS_R     = RW'(ROWS);
	localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);

	logic [BYTE_W-1:0] char_mem [CELLS];
	logic [BYTE_W-1:0] attr_mem [CELLS];

	logic [NIB_W-1:0]   fg_q, bg_q;
	logic [BYTE_W-1:0]  cur_attr;
	kind_t              kind_q;
	logic [CODE_W-1:0]  code_q;
	logic [INDEX_W-1:0] idx_q;
	logic               in_range_q;

	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic [AW-1:0] walk_q;
	logic [AW-1:0] put_addr;
	logic          put_wr;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [AW:0]   copy_addr;
	logic [BYTE_W-1:0] rd_char_q, rd_attr_q;

	logic              wr_char_s1, wr_attr_s1, copy_s1;
	logic [AW-1:0]     wr_addr_s1;
	logic [BYTE_W-1:0] char_val_s1, attr_val_s1;

	logic copy_phase;

	assign cur_attr  = {bg_q, fg_q};
	assign copy_phase = (walk_q < COPY_END);
	assign copy_addr = {1'b0, walk_q} + COLS_WIDE;
	assign put_addr  = AW'(row_q) * COLS_A + AW'(col_q);
	assign put_wr    = cmd.put_go && (code_q != NEWLINE_CODE);

	assign status.row_full   = (row_q == ROWS_R);
	assign status.sweep_last = (walk_q == LAST_CELL);
	assign status.out_free   = !out_valid || out_ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_wr_index == REG_TEXT_FG) fg_q <= cfg_wr_data;
			if (cfg_wr_index == REG_TEXT_BG) bg_q <= cfg_wr_data;
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q     <= kind_t'(in_kind);
			code_q     <= in_code;
			idx_q      <= in_index;
			in_range_q <= (32'(in_index) < CELLS);
		end
	end

	// cursor
	always_comb begin
		col_d = col_q;
		row_d = row_q;
		if (code_q == NEWLINE_CODE || col_q == LAST_COL) begin
			col_d = '0;
			row_d = row_q + 1'b1;
		end else begin
			col_d = col_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.cursor_clear) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.row_fix) begin
			row_q <= LAST_ROW;
		end else if (cmd.put_go) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	// sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) walk_q <= '0;
		else if (cmd.sweep == SW_NONE || walk_q == LAST_CELL) walk_q <= '0;
		else walk_q <= walk_q + 1'b1;
	end

	// memory read
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(idx_q);
		if (cmd.read_go) begin
			rd_en = in_range_q;
		end else if (cmd.sweep == SW_SCROLL && copy_phase) begin
			rd_en   = 1'b1;
			rd_addr = copy_addr[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_char_q <= char_mem[rd_addr];
			rd_attr_q <= attr_mem[rd_addr];
		end
	end

	// write stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_char_s1 <= 1'b0;
			wr_attr_s1 <= 1'b0;
			copy_s1    <= 1'b0;
		end else begin
			wr_char_s1 <= put_wr || cmd.sweep == SW_SCROLL || cmd.sweep == SW_CLEAR;
			wr_attr_s1 <= put_wr || cmd.sweep != SW_NONE;
			copy_s1    <= (cmd.sweep == SW_SCROLL) && copy_phase;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1  <= cmd.put_go ? put_addr : walk_q;
		char_val_s1 <= cmd.put_go ? code_q : SPACE_CODE;
		attr_val_s1 <= cur_attr;
	end

	always_ff @(posedge clk) begin
		if (wr_char_s1) char_mem[wr_addr_s1] <= copy_s1 ? rd_char_q : char_val_s1;
		if (wr_attr_s1) attr_mem[wr_addr_s1] <= copy_s1 ? rd_attr_q : attr_val_s1;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.put_go) begin
				out_col <= COL_W'(col_d);
				out_row <= ROW_W'(row_d);
			end else begin
				out_col <= COL_W'(col_q);
				out_row <= ROW_W'(row_q);
			end
			if (kind_q == KIND_READ && in_range_q) begin
				out_char <= rd_char_q;
				out_attr <= rd_attr_q;
			end else begin
				out_char <= '0;
				out_attr <= '0;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/text_console_writer_unit.sv
// Put: the put state loads the result once the output is free; a new beat is taken only in idle.
// Put at a full screen first scrolls, one cell per cycle: each row moves up one and the last row is blanked.
// Clear and repaint sweep every cell, one cell per cycle through the write port.
// Read: the read state issues the registered memory read; the final state loads its data once the output is free.
// Reset: cursor 0, foreground 7, background 0; cell memories are not cleared.
// Top level of the text console writer; instantiates tcw_ctrl and tcw_dpath, uses tcw_pkg.
`default_nettype none
module text_console_writer_unit
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
	input  wire logic [NIB_W-1:0]      cfg_wr_data,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // char_code[7:0], cell_index[18:8]
	input  wire logic [KIND_W-1:0]     s_axis_tuser,  // kind[1:0]
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata   // cursor_col[6:0], cursor_row[11:7],
	                                                  // read_char[19:12], read_attr[27:20]
);

	cmd_t              cmd;
	status_t           status;
	logic [COL_W-1:0]  cursor_col;
	logic [ROW_W-1:0]  cursor_row;
	logic [BYTE_W-1:0] read_char;
	logic [BYTE_W-1:0] read_attr;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tcw_dpath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.in_kind      (s_axis_tuser),
		.in_code      (s_axis_tdata[CODE_W-1:0]),
		.in_index     (s_axis_tdata[CODE_W+INDEX_W-1:CODE_W]),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_index (cfg_wr_index),
		.cfg_wr_data  (cfg_wr_data),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_col      (cursor_col),
		.out_row      (cursor_row),
		.out_char     (read_char),
		.out_attr     (read_attr)
	);

	assign m_axis_tdata = {
		(OUT_DATA_W - COL_W - ROW_W - 2 * BYTE_W)'(0),
		read_attr, read_char, cursor_row, cursor_col
	};

endmodule
`default_nettype wire
